// ===== sv/lcdnw_pkg.sv =====
// Shared types, codes and the microcode ROM of the character LCD nibble writer.
`timescale 1ns / 1ps

package lcdnw_pkg;

   // Request kinds carried on the request tuser.
   typedef enum logic [1:0] {
      OP_CHAR   = 2'd0,
      OP_CMD    = 2'd1,
      OP_CURSOR = 2'd2,
      OP_INIT   = 2'd3
   } opcode_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_PULSE   = 2'd0,
      CSR_SETTLE  = 2'd1,
      CSR_POWERUP = 2'd2,
      CSR_NONE    = 2'd3
   } csr_index_type;

   localparam logic [15:0] PULSE_RESET   = 16'd1000;
   localparam logic [15:0] SETTLE_RESET  = 16'd20000;
   localparam logic [15:0] POWERUP_RESET = 16'd50000;

   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CURSOR_ROW1      = 8'h80;
   localparam logic [7:0] CURSOR_ROW2      = 8'hC0;

   // Where the byte of a step comes from.
   typedef enum logic [2:0] {
      SRC_REQ  = 3'd0,
      SRC_ZERO = 3'd1,
      SRC_28   = 3'd2,
      SRC_0C   = 3'd3,
      SRC_06   = 3'd4,
      SRC_01   = 3'd5
   } byte_src_type;

   // Which hold time a step carries.
   typedef enum logic [1:0] {
      HOLD_PULSE   = 2'd0,
      HOLD_ZERO    = 2'd1,
      HOLD_SETTLE  = 2'd2,
      HOLD_POWERUP = 2'd3
   } hold_sel_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   // One control word of the microprogram.
   typedef struct packed {
      byte_src_type src;
      logic         nib_lo;
      logic         enable;
      hold_sel_type hold;
      logic         last;
   } ctrl_type;

   localparam int STEP_COUNT = 22;
   localparam int STEP_W     = $clog2(STEP_COUNT);

   localparam logic [STEP_W-1:0] BYTE_ENTRY = STEP_W'(0);
   localparam logic [STEP_W-1:0] INIT_ENTRY = STEP_W'(4);

   // One of the four pin states of a byte transfer.
   function automatic ctrl_type byte_phase(byte_src_type src, logic [1:0] phase,
                                           logic last);
      ctrl_type w;
      w.src    = src;
      w.nib_lo = phase[1];
      w.enable = ~phase[0];
      w.last   = 1'b0;
      case (phase)
         2'd0:    w.hold = HOLD_PULSE;
         2'd1:    w.hold = HOLD_ZERO;
         2'd2:    w.hold = HOLD_PULSE;
         default: begin
            w.hold = HOLD_SETTLE;
            w.last = last;
         end
      endcase
      return w;
   endfunction

   // Microcode ROM. The byte program starts at step 0, the power-up program at step 4.
   function automatic ctrl_type rom_word(logic [STEP_W-1:0] step);
      ctrl_type w;
      w = byte_phase(SRC_ZERO, 2'd1, 1'b0);
      case (step)
         5'd0:  w = byte_phase(SRC_REQ, 2'd0, 1'b1);
         5'd1:  w = byte_phase(SRC_REQ, 2'd1, 1'b1);
         5'd2:  w = byte_phase(SRC_REQ, 2'd2, 1'b1);
         5'd3:  w = byte_phase(SRC_REQ, 2'd3, 1'b1);
         5'd4:  begin
            w.src    = SRC_ZERO;
            w.nib_lo = 1'b0;
            w.enable = 1'b0;
            w.hold   = HOLD_POWERUP;
            w.last   = 1'b0;
         end
         5'd5:  w = byte_phase(SRC_28, 2'd0, 1'b0);
         5'd6:  w = byte_phase(SRC_28, 2'd1, 1'b0);
         5'd7:  w = byte_phase(SRC_28, 2'd2, 1'b0);
         5'd8:  w = byte_phase(SRC_28, 2'd3, 1'b0);
         5'd9:  w = byte_phase(SRC_0C, 2'd0, 1'b0);
         5'd10: w = byte_phase(SRC_0C, 2'd1, 1'b0);
         5'd11: w = byte_phase(SRC_0C, 2'd2, 1'b0);
         5'd12: w = byte_phase(SRC_0C, 2'd3, 1'b0);
         5'd13: w = byte_phase(SRC_06, 2'd0, 1'b0);
         5'd14: w = byte_phase(SRC_06, 2'd1, 1'b0);
         5'd15: w = byte_phase(SRC_06, 2'd2, 1'b0);
         5'd16: w = byte_phase(SRC_06, 2'd3, 1'b0);
         5'd17: w = byte_phase(SRC_01, 2'd0, 1'b0);
         5'd18: w = byte_phase(SRC_01, 2'd1, 1'b0);
         5'd19: w = byte_phase(SRC_01, 2'd2, 1'b0);
         5'd20: w = byte_phase(SRC_01, 2'd3, 1'b0);
         5'd21: begin
            // Closing wait keeps the pins of the clear command's last state.
            w.src    = SRC_01;
            w.nib_lo = 1'b1;
            w.enable = 1'b0;
            w.hold   = HOLD_POWERUP;
            w.last   = 1'b1;
         end
         default: w = byte_phase(SRC_ZERO, 2'd1, 1'b1);
      endcase
      return w;
   endfunction

endpackage

// ===== sv/lcdnw_sequencer.sv =====
// Microprogram sequencer: step counter, entry dispatch and ROM lookup.
`timescale 1ns / 1ps

module lcdnw_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  lcdnw_pkg::opcode_type       opcode,
   input  logic                        advance,
   output logic                        busy,
   output lcdnw_pkg::ctrl_type         ctrl
);
   import lcdnw_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign ctrl = rom_word(step_ff);
   assign busy = (state_ff == SEQ_RUN);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_RUN;
               step_in  = (opcode == OP_INIT) ? INIT_ENTRY : BYTE_ENTRY;
            end
         end
         SEQ_RUN: begin
            if (advance) begin
               if (ctrl.last) begin
                  state_in = SEQ_IDLE;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= BYTE_ENTRY;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // The step counter never runs past the end of the ROM.
   a_step_in_rom: assert property (@(posedge clock) disable iff (reset)
      busy |-> (step_ff < STEP_W'(STEP_COUNT)))
      else $error("sequencer step outside the microprogram");

   // The sequencer only goes idle after handing over a final step.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> $past(advance && ctrl.last))
      else $error("sequencer stopped before the final step");

   // A started program always begins at one of the two entry points.
   a_entry: assert property (@(posedge clock) disable iff (reset)
      (!busy && start) |=> (busy && (step_ff == BYTE_ENTRY || step_ff == INIT_ENTRY)))
      else $error("program did not start at an entry point");

endmodule

// ===== sv/lcdnw_datapath.sv =====
// Datapath: configuration registers, request byte register and pin state fields.
`timescale 1ns / 1ps

module lcdnw_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  lcdnw_pkg::csr_index_type  csr_index,
   input  logic [15:0]               csr_data,
   input  logic                      start,
   input  lcdnw_pkg::opcode_type     opcode,
   input  logic [7:0]                data_byte,
   input  logic [1:0]                row,
   input  logic [5:0]                column,
   input  lcdnw_pkg::ctrl_type       ctrl,
   output logic                      reg_select,
   output logic                      enable,
   output logic [3:0]                data_nibble,
   output logic [15:0]               hold_ticks,
   output logic                      last
);
   import lcdnw_pkg::*;

   logic [15:0] pulse_ff, settle_ff, powerup_ff;
   logic [7:0]  byte_ff, byte_in;
   logic        rs_ff, rs_in;
   logic [7:0]  cursor_base;
   logic [7:0]  step_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff   <= PULSE_RESET;
         settle_ff  <= SETTLE_RESET;
         powerup_ff <= POWERUP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PULSE:   pulse_ff   <= csr_data;
            CSR_SETTLE:  settle_ff  <= csr_data;
            CSR_POWERUP: powerup_ff <= csr_data;
            default:     ;
         endcase
      end
   end

   // Cursor command wraps modulo 256, so column zero lands one below the base.
   assign cursor_base = (row == 2'd1) ? CURSOR_ROW1 : CURSOR_ROW2;

   always_comb begin
      byte_in = byte_ff;
      rs_in   = rs_ff;
      if (start) begin
         rs_in = (opcode == OP_CHAR);
         if (opcode == OP_CURSOR) begin
            byte_in = cursor_base + {2'b00, column} - 8'd1;
         end else begin
            byte_in = data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      rs_ff   <= rs_in;
   end

   always_comb begin
      case (ctrl.src)
         SRC_REQ:  step_byte = byte_ff;
         SRC_28:   step_byte = CMD_FUNCTION_SET;
         SRC_0C:   step_byte = CMD_DISPLAY_ON;
         SRC_06:   step_byte = CMD_ENTRY_MODE;
         SRC_01:   step_byte = CMD_CLEAR;
         default:  step_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (ctrl.hold)
         HOLD_PULSE:   hold_ticks = pulse_ff;
         HOLD_SETTLE:  hold_ticks = settle_ff;
         HOLD_POWERUP: hold_ticks = powerup_ff;
         default:      hold_ticks = 16'd0;
      endcase
   end

   // Only the byte program carries the request's register select.
   assign reg_select  = (ctrl.src == SRC_REQ) ? rs_ff : 1'b0;
   assign enable      = ctrl.enable;
   assign data_nibble = ctrl.nib_lo ? step_byte[3:0] : step_byte[7:4];
   assign last        = ctrl.last;

endmodule

// ===== sv/char_lcd_nibble_writer_top.sv =====
// Top level of the character LCD nibble writer: stream ports and result register.
`timescale 1ns / 1ps

// Each request turns into a list of LCD pin states, one beat per clock cycle
// when the sink is ready: four beats for a character, a command or a cursor
// move, eighteen for the power-up sequence. A microcode sequencer walks one
// ROM step per cycle unless the result side stalls, four or eighteen per request;
// a new request is accepted in the cycle after the final state has moved into
// the result register, while that state may still wait for the sink. A stall on
// the result side holds the step counter. The user must write the three hold
// times through the csr port only while no request is in flight (unenforced).
module char_lcd_nibble_writer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], row[9:8], column[15:10]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // enable[0], data_nibble[4:1], hold_ticks[20:5], zero
   output logic [0:0]  rsp_tuser,   // reg_select[0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import lcdnw_pkg::*;

   logic        start;
   logic        advance;
   logic        busy;
   ctrl_type    ctrl;
   opcode_type  opcode;
   logic        reg_select;
   logic        enable;
   logic [3:0]  data_nibble;
   logic [15:0] hold_ticks;
   logic        last;

   logic        valid_ff, valid_in;
   logic [20:0] data_ff;
   logic        rs_ff;
   logic        last_ff;

   assign opcode     = opcode_type'(req_tuser);
   assign req_tready = ~busy;
   assign start      = req_tvalid & ~busy;
   assign advance    = busy & (~valid_ff | rsp_tready);
   assign csr_ready  = 1'b1;

   lcdnw_sequencer u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .opcode  (opcode),
      .advance (advance),
      .busy    (busy),
      .ctrl    (ctrl)
   );

   lcdnw_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid),
      .csr_index   (csr_index_type'(csr_index)),
      .csr_data    (csr_data),
      .start       (start),
      .opcode      (opcode),
      .data_byte   (req_tdata[7:0]),
      .row         (req_tdata[9:8]),
      .column      (req_tdata[15:10]),
      .ctrl        (ctrl),
      .reg_select  (reg_select),
      .enable      (enable),
      .data_nibble (data_nibble),
      .hold_ticks  (hold_ticks),
      .last        (last)
   );

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= {hold_ticks, data_nibble, enable};
         rs_ff   <= reg_select;
         last_ff <= last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, data_ff};
   assign rsp_tuser  = rs_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking stream testbench for the character LCD nibble writer.
`timescale 1ns / 1ps

module testbench;
   import lcdnw_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_PER_SET = 52;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      opcode_type  opcode;
      logic [7:0]  data_byte;
      logic [1:0]  row;
      logic [5:0]  column;
   } lcd_request_type;

   typedef struct {
      logic        reg_select;
      logic        enable;
      logic [3:0]  nibble;
      logic [15:0] hold_ticks;
      logic        last;
   } pin_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // data_byte[7:0], row[9:8], column[15:10]
   logic [1:0]  req_tuser = '0;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // enable[0], data_nibble[4:1], hold_ticks[20:5], zero
   logic [0:0]  rsp_tuser;        // reg_select[0]
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   lcd_request_type request_backlog[$];
   lcd_request_type request_on_bus;
   pin_state_type   pin_states_due[$];

   logic [15:0] pulse_ticks   = PULSE_RESET;
   logic [15:0] settle_ticks  = SETTLE_RESET;
   logic [15:0] powerup_ticks = POWERUP_RESET;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatch_count     = 0;
   int cycle_count        = 0;

   char_lcd_nibble_writer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   task automatic push_pin_state(input logic rs, input logic en, input logic [3:0] nib,
                                 input logic [15:0] hold, input logic fin);
      pin_state_type s;
      s.reg_select = rs;
      s.enable     = en;
      s.nibble     = nib;
      s.hold_ticks = hold;
      s.last       = fin;
      pin_states_due.push_back(s);
   endtask

   task automatic push_byte_states(input logic [7:0] value, input logic rs, input logic fin);
      push_pin_state(rs, 1'b1, value[7:4], pulse_ticks, 1'b0);
      push_pin_state(rs, 1'b0, value[7:4], 16'd0, 1'b0);
      push_pin_state(rs, 1'b1, value[3:0], pulse_ticks, 1'b0);
      push_pin_state(rs, 1'b0, value[3:0], settle_ticks, fin);
   endtask

   task automatic predict_pin_states(input lcd_request_type r);
      logic [7:0] cursor_cmd;
      case (r.opcode)
         OP_CHAR: push_byte_states(r.data_byte, 1'b1, 1'b1);
         OP_CMD:  push_byte_states(r.data_byte, 1'b0, 1'b1);
         OP_CURSOR: begin
            // Column zero wraps within the byte.
            cursor_cmd = ((r.row == 2'd1) ? CURSOR_ROW1 : CURSOR_ROW2)
                         + {2'b00, r.column} - 8'd1;
            push_byte_states(cursor_cmd, 1'b0, 1'b1);
         end
         default: begin
            push_pin_state(1'b0, 1'b0, 4'h0, powerup_ticks, 1'b0);
            push_byte_states(CMD_FUNCTION_SET, 1'b0, 1'b0);
            push_byte_states(CMD_DISPLAY_ON, 1'b0, 1'b0);
            push_byte_states(CMD_ENTRY_MODE, 1'b0, 1'b0);
            push_byte_states(CMD_CLEAR, 1'b0, 1'b0);
            // The closing wait keeps the pins of the clear command's last state.
            push_pin_state(1'b0, 1'b0, 4'h1, powerup_ticks, 1'b1);
         end
      endcase
   endtask

   // Request driver: one beat per handshake, gaps drawn per cycle.
   always @(posedge clock) begin : request_driver
      logic load_next;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         load_next = !req_tvalid;
         if (req_tvalid && req_tready) begin
            predict_pin_states(request_on_bus);
            load_next = 1'b1;
         end
         if (load_next) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               request_on_bus = request_backlog.pop_front();
               req_tdata  <= {request_on_bus.column, request_on_bus.row,
                              request_on_bus.data_byte};
               req_tuser  <= request_on_bus.opcode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Pin state monitor: compares every accepted beat with the oldest prediction.
   always @(posedge clock) begin : pin_state_monitor
      pin_state_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pin_states_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected pin state beat: tdata=%h tuser=%b tlast=%b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = pin_states_due.pop_front();
               if (rsp_tuser[0] !== want.reg_select || rsp_tdata[0] !== want.enable ||
                   rsp_tdata[4:1] !== want.nibble || rsp_tdata[20:5] !== want.hold_ticks ||
                   rsp_tdata[23:21] !== 3'b000 || rsp_tlast !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("pin state mismatch: expected rs=%b en=%b nib=%h hold=%0d last=%b",
                              want.reg_select, want.enable, want.nibble, want.hold_ticks,
                              want.last);
                     $display("   got rs=%b en=%b nib=%h hold=%0d last=%b pad=%b",
                              rsp_tuser[0], rsp_tdata[0], rsp_tdata[4:1],
                              rsp_tdata[20:5], rsp_tlast, rsp_tdata[23:21]);
                  end
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic queue_request(input opcode_type op, input logic [7:0] data,
                                input logic [1:0] row, input logic [5:0] column);
      lcd_request_type r;
      r.opcode    = op;
      r.data_byte = data;
      r.row       = row;
      r.column    = column;
      request_backlog.push_back(r);
   endtask

   // Caller sits at a rising edge; returns at the edge that accepted the write.
   task automatic write_csr(input csr_index_type index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_PULSE:   pulse_ticks   = value;
         CSR_SETTLE:  settle_ticks  = value;
         CSR_POWERUP: powerup_ticks = value;
         default:     ;
      endcase
   endtask

   task automatic load_hold_times(input logic [15:0] pulse, input logic [15:0] settle,
                                  input logic [15:0] powerup);
      @(posedge clock);
      write_csr(CSR_PULSE, pulse);
      write_csr(CSR_SETTLE, settle);
      write_csr(CSR_POWERUP, powerup);
      // Writes to the unused index must leave every hold time alone.
      write_csr(CSR_NONE, 16'($urandom));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      while (request_backlog.size() != 0 || req_tvalid || pin_states_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_random_set(input int idle_pct, input int stall_pct);
      logic [1:0] row;
      logic [5:0] column;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < RANDOM_PER_SET; i++) begin
         // Mostly legal cursor targets, with the odd row or column outside them.
         if ($urandom_range(9) == 0) begin
            row    = 2'($urandom);
            column = 6'($urandom);
         end else begin
            row    = 2'($urandom_range(2, 1));
            column = 6'($urandom_range(40, 1));
         end
         queue_request(opcode_type'($urandom_range(3)), 8'($urandom), row, column);
      end
      wait_until_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats under the reset hold times, no idling on either side.
      queue_request(OP_CHAR, 8'h00, 2'd0, 6'd0);
      queue_request(OP_CHAR, 8'hFF, 2'd3, 6'd63);
      queue_request(OP_CHAR, 8'hA5, 2'd1, 6'd1);
      queue_request(OP_CMD, 8'h00, 2'd2, 6'd40);
      queue_request(OP_CMD, 8'hFF, 2'd0, 6'd0);
      queue_request(OP_CMD, 8'h5A, 2'd3, 6'd63);
      queue_request(OP_CURSOR, 8'h00, 2'd1, 6'd1);
      queue_request(OP_CURSOR, 8'hFF, 2'd1, 6'd40);
      queue_request(OP_CURSOR, 8'h00, 2'd2, 6'd1);
      queue_request(OP_CURSOR, 8'hFF, 2'd2, 6'd40);
      queue_request(OP_CURSOR, 8'h3C, 2'd0, 6'd5);
      queue_request(OP_CURSOR, 8'hC3, 2'd3, 6'd17);
      queue_request(OP_CURSOR, 8'h00, 2'd1, 6'd0);
      queue_request(OP_CURSOR, 8'h00, 2'd2, 6'd0);
      queue_request(OP_CURSOR, 8'h00, 2'd1, 6'd63);
      queue_request(OP_CURSOR, 8'h00, 2'd2, 6'd63);
      queue_request(OP_INIT, 8'h00, 2'd0, 6'd0);
      queue_request(OP_INIT, 8'hFF, 2'd3, 6'd63);
      queue_request(OP_CHAR, 8'h41, 2'd1, 6'd1);
      wait_until_drained();

      load_hold_times(16'd0, 16'd0, 16'd0);
      queue_request(OP_INIT, 8'h12, 2'd1, 6'd2);
      run_random_set(0, 0);

      load_hold_times(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_request(OP_INIT, 8'h34, 2'd2, 6'd3);
      run_random_set(47, 0);

      load_hold_times(16'($urandom), 16'($urandom), 16'($urandom));
      run_random_set(0, 47);

      load_hold_times(16'($urandom), 16'($urandom), 16'($urandom));
      run_random_set(12, 12);

      // Let any stray beat show up before the verdict.
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pin_states_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== char_lcd_nibble_writer_top.f =====
sv/lcdnw_pkg.sv
sv/lcdnw_sequencer.sv
sv/lcdnw_datapath.sv
sv/char_lcd_nibble_writer_top.sv
verif/testbench.sv
